@@ sv/rnsalu_pkg.sv @@
// ----------------------------------------------------------------------------
// rnsalu_pkg
// Types and constants for the three-modulus residue ALU with CRT output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rnsalu_pkg;

   typedef enum logic [1:0] {
      CMD_ADD,
      CMD_SUB,
      CMD_MUL,
      CMD_DIV
   } cmd_type;

   localparam int LANES = 3;

   // residue lanes: 19, 23, 31
   localparam logic [4:0] MODULI [LANES] = '{5'd19, 5'd23, 5'd31};

   // product of the moduli
   localparam logic [13:0] MOD_M = 14'd13547;

   // fixed point reciprocals for reduction by a constant
   localparam int RECIP_SHIFT = 20;
   localparam logic [16:0] LANE_RECIP [LANES] = '{
      17'((1 << RECIP_SHIFT) / 19),
      17'((1 << RECIP_SHIFT) / 23),
      17'((1 << RECIP_SHIFT) / 31)
   };
   localparam logic [6:0] CRT_RECIP = 7'((1 << RECIP_SHIFT) / 13547);

   // 256^k mod p, used to fold the operand bytes
   localparam logic [4:0] BYTE_WT [LANES][4] = '{
      '{5'd1, 5'd9, 5'd5, 5'd7},
      '{5'd1, 5'd3, 5'd9, 5'd4},
      '{5'd1, 5'd8, 5'd2, 5'd16}
   };

   // CRT weights: (M/p) * inverse(M/p mod p), taken mod M
   localparam logic [13:0] CRT_WEIGHT [LANES] = '{14'd1426, 14'd2945, 14'd9177};

   // modular inverse per residue, entry zero unused
   localparam logic [4:0] INV_TABLE [LANES][32] = '{
      '{5'd0,  5'd1,  5'd10, 5'd13, 5'd5,  5'd4,  5'd16, 5'd11,
        5'd12, 5'd17, 5'd2,  5'd7,  5'd8,  5'd3,  5'd15, 5'd14,
        5'd6,  5'd9,  5'd18, 5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
        5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0},
      '{5'd0,  5'd1,  5'd12, 5'd8,  5'd6,  5'd14, 5'd4,  5'd10,
        5'd3,  5'd18, 5'd7,  5'd21, 5'd2,  5'd16, 5'd5,  5'd20,
        5'd13, 5'd19, 5'd9,  5'd17, 5'd15, 5'd11, 5'd22, 5'd0,
        5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0},
      '{5'd0,  5'd1,  5'd16, 5'd21, 5'd8,  5'd25, 5'd26, 5'd9,
        5'd4,  5'd7,  5'd28, 5'd17, 5'd13, 5'd12, 5'd20, 5'd29,
        5'd2,  5'd11, 5'd19, 5'd18, 5'd14, 5'd3,  5'd24, 5'd27,
        5'd22, 5'd5,  5'd6,  5'd23, 5'd10, 5'd15, 5'd30, 5'd0}
   };

   typedef logic [LANES-1:0][4:0] res_vec_type;

   typedef struct packed {
      logic load_sum;
      logic load_out;
   } crt_ctl_type;

endpackage

`default_nettype wire

@@ sv/rnsalu_if.sv @@
// ----------------------------------------------------------------------------
// rnsalu_if
// Request and response channels of the residue ALU.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rnsalu_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [31:0] operand_x;
   logic [31:0] operand_y;

   modport source (output valid, output cmd, output operand_x, output operand_y,
                   input ready);
   modport sink   (input valid, input cmd, input operand_x, input operand_y,
                   output ready);
endinterface

interface rnsalu_rsp_if;
   logic        valid;
   logic        ready;
   logic [13:0] result_value;
   logic        not_possible;

   modport source (output valid, output result_value, output not_possible,
                   input ready);
   modport sink   (input valid, input result_value, input not_possible,
                   output ready);
endinterface

`default_nettype wire

@@ sv/rnsalu_crt.sv @@
// ----------------------------------------------------------------------------
// rnsalu_crt
// Two stage CRT recombination of the lane residues modulo 13547.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rnsalu_crt
   import rnsalu_pkg::*;
(
   input  wire         clock,
   input  crt_ctl_type ctl,
   input  res_vec_type lane_res,
   input  wire         fail,
   output logic [13:0] result_value,
   output logic        not_possible
);

   logic [18:0] sum_ff, sum_in;
   logic        fail_sum_ff;
   logic [13:0] result_ff, result_in;
   logic        fail_out_ff;

   logic [25:0] crt_prod;
   logic [5:0]  crt_q;
   logic [19:0] crt_qm;
   logic [18:0] crt_rem;

   // weighted sum stays below 2^19 for residues below their moduli
   always_comb begin
      sum_in = '0;
      for (int i = 0; i < LANES; i++) begin
         sum_in = sum_in + 19'(19'(lane_res[i]) * 19'(CRT_WEIGHT[i]));
      end
   end

   always_comb begin
      crt_prod = 26'(sum_ff) * 26'(CRT_RECIP);
      crt_q    = crt_prod[25:20];
      crt_qm   = 20'(crt_q) * 20'(MOD_M);
      crt_rem  = sum_ff - crt_qm[18:0];
      if (crt_rem >= 19'(MOD_M)) begin
         crt_rem = crt_rem - 19'(MOD_M);
      end
      result_in = fail_sum_ff ? '0 : crt_rem[13:0];
   end

   always_ff @(posedge clock) begin
      if (ctl.load_sum) begin
         sum_ff      <= sum_in;
         fail_sum_ff <= fail;
      end
      if (ctl.load_out) begin
         result_ff   <= result_in;
         fail_out_ff <= fail_sum_ff;
      end
   end

   assign result_value = result_ff;
   assign not_possible = fail_out_ff;

endmodule

`default_nettype wire

@@ sv/rns_alu_with_crt_reconstruction.sv @@
// pipeline: seven stages from a request transfer to the earliest response transfer
// throughput: one item per cycle; each stage holds while the stage after it is full
// and stalled, so back pressure reaches req ready only when the whole pipe is full
// reset: synchronous, clears all stage valid bits; no clearing pass, usable at once
// ----------------------------------------------------------------------------
// rns_alu_with_crt_reconstruction
// Residue ALU over moduli 19, 23 and 31 with CRT recombination mod 13547.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rns_alu_with_crt_reconstruction
   import rnsalu_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   rnsalu_req_if.sink   req_if,
   rnsalu_rsp_if.source rsp_if
);

   localparam int STAGES = 7;

   // residue of a value below 2^16 by multiply with a reciprocal and one fixup
   function automatic logic [4:0] mod_res(input logic [15:0] v, input logic [4:0] p,
                                          input logic [16:0] recip);
      logic [32:0] prod;
      logic [12:0] q;
      logic [17:0] qp;
      logic [15:0] rem;
      prod = 33'(v) * 33'(recip);
      q    = prod[32:20];
      qp   = 18'(q) * 18'(p);
      rem  = v - qp[15:0];
      if (rem >= 16'(p)) begin
         rem = rem - 16'(p);
      end
      return rem[4:0];
   endfunction

   logic [STAGES-1:0] vld_ff;
   logic [STAGES:0]   adv;

   // stage 1: byte folding
   cmd_type                cmd1_ff;
   logic [LANES-1:0][14:0] xsum_ff, xsum_in, ysum_ff, ysum_in;
   // stage 2: residues
   cmd_type     cmd2_ff;
   res_vec_type ra2_ff, ra2_in, rb2_ff, rb2_in;
   // stage 3: divisor inverse
   cmd_type     cmd3_ff;
   res_vec_type ra3_ff, rb3_ff, bsel3_ff, bsel3_in;
   logic        fail3_ff, fail3_in;
   // stage 4: add / subtract and raw product
   cmd_type                cmd4_ff;
   res_vec_type            addsub4_ff, addsub4_in;
   logic [LANES-1:0][9:0]  prod4_ff, prod4_in;
   logic                   fail4_ff;
   // stage 5: lane result
   res_vec_type res5_ff, res5_in;
   logic        fail5_ff;

   crt_ctl_type crt_ctl;

   always_comb begin
      adv[STAGES] = rsp_if.ready;
      for (int k = STAGES - 1; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= req_if.valid;
         end
         for (int k = 1; k < STAGES; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         xsum_in[i] = '0;
         ysum_in[i] = '0;
         for (int b = 0; b < 4; b++) begin
            xsum_in[i] = xsum_in[i]
                       + 15'(15'(req_if.operand_x[8*b +: 8]) * 15'(BYTE_WT[i][b]));
            ysum_in[i] = ysum_in[i]
                       + 15'(15'(req_if.operand_y[8*b +: 8]) * 15'(BYTE_WT[i][b]));
         end
      end
   end

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         ra2_in[i] = mod_res(16'(xsum_ff[i]), MODULI[i], LANE_RECIP[i]);
         rb2_in[i] = mod_res(16'(ysum_ff[i]), MODULI[i], LANE_RECIP[i]);
      end
   end

   always_comb begin
      fail3_in = 1'b0;
      for (int i = 0; i < LANES; i++) begin
         bsel3_in[i] = (cmd2_ff == CMD_DIV) ? INV_TABLE[i][rb2_ff[i]] : rb2_ff[i];
         if (cmd2_ff == CMD_DIV && rb2_ff[i] == '0) begin
            fail3_in = 1'b1;
         end
      end
   end

   always_comb begin
      logic [5:0] tmp;
      for (int i = 0; i < LANES; i++) begin
         if (cmd3_ff == CMD_SUB) begin
            tmp = 6'(ra3_ff[i]) + 6'(MODULI[i]) - 6'(rb3_ff[i]);
         end else begin
            tmp = 6'(ra3_ff[i]) + 6'(rb3_ff[i]);
         end
         if (tmp >= 6'(MODULI[i])) begin
            tmp = tmp - 6'(MODULI[i]);
         end
         addsub4_in[i] = tmp[4:0];
         prod4_in[i]   = 10'(ra3_ff[i]) * 10'(bsel3_ff[i]);
      end
   end

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         if (cmd4_ff == CMD_ADD || cmd4_ff == CMD_SUB) begin
            res5_in[i] = addsub4_ff[i];
         end else begin
            res5_in[i] = mod_res(16'(prod4_ff[i]), MODULI[i], LANE_RECIP[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         cmd1_ff <= cmd_type'(req_if.cmd);
         xsum_ff <= xsum_in;
         ysum_ff <= ysum_in;
      end
      if (adv[1]) begin
         cmd2_ff <= cmd1_ff;
         ra2_ff  <= ra2_in;
         rb2_ff  <= rb2_in;
      end
      if (adv[2]) begin
         cmd3_ff  <= cmd2_ff;
         ra3_ff   <= ra2_ff;
         rb3_ff   <= rb2_ff;
         bsel3_ff <= bsel3_in;
         fail3_ff <= fail3_in;
      end
      if (adv[3]) begin
         cmd4_ff    <= cmd3_ff;
         addsub4_ff <= addsub4_in;
         prod4_ff   <= prod4_in;
         fail4_ff   <= fail3_ff;
      end
      if (adv[4]) begin
         res5_ff  <= res5_in;
         fail5_ff <= fail4_ff;
      end
   end

   assign crt_ctl.load_sum = adv[5];
   assign crt_ctl.load_out = adv[6];

   rnsalu_crt u_crt (
      .clock        (clock),
      .ctl          (crt_ctl),
      .lane_res     (res5_ff),
      .fail         (fail5_ff),
      .result_value (rsp_if.result_value),
      .not_possible (rsp_if.not_possible)
   );

   assign req_if.ready = adv[0];
   assign rsp_if.valid = vld_ff[STAGES-1];

   a_accept_fills_first: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> vld_ff[0])
      else $error("accepted request did not reach the first stage");

   a_fail_only_div: assert property (@(posedge clock) disable iff (reset)
      vld_ff[2] && fail3_ff |-> cmd3_ff == CMD_DIV)
      else $error("not possible flag raised outside division");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.not_possible |-> rsp_if.result_value == '0)
      else $error("failed division returned a nonzero result");

   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> rsp_if.result_value < MOD_M)
      else $error("result not reduced below the modulus product");

   a_full_pipe_stall: assert property (@(posedge clock) disable iff (reset)
      (&vld_ff) && !rsp_if.ready |-> !req_if.ready)
      else $error("request taken while the pipe is full and stalled");

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the residue ALU: a queue-fed driver pushes operations
// and operand pairs, a monitor predicts each CRT result and checks every one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb
   import rnsalu_pkg::*;
();

   localparam int unsigned LANE_P [3] = '{19, 23, 31};
   localparam int unsigned CRT_MOD = 19 * 23 * 31;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 20;
   localparam int RANDOM_PER_PHASE = 660;

   typedef struct packed {
      cmd_type     op;
      logic [31:0] x;
      logic [31:0] y;
   } alu_op_type;

   typedef struct packed {
      logic [13:0] value;
      logic        flag;
   } crt_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rnsalu_req_if req_bus ();
   rnsalu_rsp_if rsp_bus ();

   rns_alu_with_crt_reconstruction dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   alu_op_type     pending_ops [$];
   crt_result_type expected_results [$];
   int             queued_count = 0;
   int             accepted_count = 0;
   int             fail_count = 0;
   int             stall_cycles = 0;
   int             tx_idle_pct = 29;
   int             rx_idle_pct = 63;
   logic           req_took = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int unsigned pow_mod(int unsigned base, int unsigned e,
                                           int unsigned p);
      int unsigned acc;
      int unsigned b;
      acc = 1;
      b = base % p;
      while (e != 0) begin
         if (e[0]) acc = (acc * b) % p;
         b = (b * b) % p;
         e = e >> 1;
      end
      return acc;
   endfunction

   // residue-wise operation, fermat inverse for divide, then crt recombination
   function automatic crt_result_type crt_predict(alu_op_type item);
      int unsigned    p;
      int unsigned    ra;
      int unsigned    rb;
      int unsigned    lane_res;
      int unsigned    m;
      int unsigned    inv;
      int unsigned    acc;
      logic           dead;
      crt_result_type rsp;
      acc = 0;
      dead = 1'b0;
      for (int i = 0; i < 3; i++) begin
         p = LANE_P[i];
         ra = item.x % p;
         rb = item.y % p;
         case (item.op)
            CMD_ADD: lane_res = (ra + rb) % p;
            CMD_SUB: lane_res = (ra + p - rb) % p;
            CMD_MUL: lane_res = (ra * rb) % p;
            default: begin
               if (rb == 0) begin
                  dead = 1'b1;
                  lane_res = 0;
               end else begin
                  lane_res = (ra * pow_mod(rb, p - 2, p)) % p;
               end
            end
         endcase
         m = CRT_MOD / p;
         inv = pow_mod(m % p, p - 2, p);
         acc = (acc + (lane_res * m * inv) % CRT_MOD) % CRT_MOD;
      end
      rsp.value = dead ? 14'd0 : acc[13:0];
      rsp.flag = dead;
      return rsp;
   endfunction

   task automatic queue_op(cmd_type op, logic [31:0] x, logic [31:0] y);
      alu_op_type item;
      item.op = op;
      item.x = x;
      item.y = y;
      pending_ops = {pending_ops, item};
      queued_count++;
   endtask

   task automatic queue_random(int count);
      int          sel;
      logic [31:0] x;
      logic [31:0] y;
      int unsigned p;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(0, 9);
         x = $urandom;
         y = $urandom;
         case (sel)
            6: begin
               x = $urandom_range(0, 40);
               y = $urandom_range(0, 40);
            end
            7: begin
               // divisor with a zero residue in one or all lanes
               case ($urandom_range(0, 3))
                  0: p = 19;
                  1: p = 23;
                  2: p = 31;
                  default: p = CRT_MOD;
               endcase
               y = $urandom_range(0, 32'hFFFF_FFFF / p) * p;
            end
            8: begin
               x = $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 3)
                                        : $urandom_range(0, 3);
               y = $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 3)
                                        : $urandom_range(0, 3);
            end
            9: y = $urandom_range(0, 1) ? 32'd1 : x;
            default: ;
         endcase
         queue_op(cmd_type'($urandom_range(0, 3)), x, y);
      end
   endtask

   // driver: a new transfer is offered once the previous one was taken
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
         if (!req_bus.valid || req_took) begin
            if (pending_ops.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
               req_bus.cmd <= pending_ops[0].op;
               req_bus.operand_x <= pending_ops[0].x;
               req_bus.operand_y <= pending_ops[0].y;
               req_bus.valid <= 1'b1;
               void'(pending_ops.pop_front());
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: predicts on request transfers, checks on response transfers
   always @(posedge clock) begin
      crt_result_type exp_rsp;
      alu_op_type     item;
      req_took <= !reset && req_bus.valid && req_bus.ready;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            item.op = cmd_type'(req_bus.cmd);
            item.x = req_bus.operand_x;
            item.y = req_bus.operand_y;
            expected_results = {expected_results, crt_predict(item)};
            accepted_count++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               $error("response with no request outstanding: result_value %0d",
                      rsp_bus.result_value);
               fail_count++;
            end else begin
               exp_rsp = expected_results.pop_front();
               if (rsp_bus.result_value !== exp_rsp.value) begin
                  $error("result_value mismatch: expected %0d, actual %0d",
                         exp_rsp.value, rsp_bus.result_value);
                  fail_count++;
               end
               if (rsp_bus.not_possible !== exp_rsp.flag) begin
                  $error("not_possible mismatch: expected %0d, actual %0d",
                         exp_rsp.flag, rsp_bus.not_possible);
                  fail_count++;
               end
            end
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
      end
   end

   always @(posedge clock) begin
      if (stall_cycles >= STALL_LIMIT) begin
         $display("FAIL rns_alu_with_crt_reconstruction");
         $finish;
      end
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.cmd = 2'd0;
      req_bus.operand_x = 32'd0;
      req_bus.operand_y = 32'd0;
      rsp_bus.ready = 1'b0;

      // directed: extremes, every operation, zero-residue divisors
      queue_op(CMD_ADD, 32'd0, 32'd0);
      queue_op(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_op(CMD_SUB, 32'd0, 32'hFFFF_FFFF);
      queue_op(CMD_SUB, 32'hFFFF_FFFF, 32'd0);
      queue_op(CMD_SUB, 32'd5, 32'd13547);
      queue_op(CMD_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_op(CMD_MUL, 32'hAAAA_AAAA, 32'h5555_5555);
      queue_op(CMD_ADD, 32'h5555_5555, 32'hAAAA_AAAA);
      queue_op(CMD_DIV, 32'd100, 32'd0);
      queue_op(CMD_DIV, 32'd100, 32'd19);
      queue_op(CMD_DIV, 32'd100, 32'd23);
      queue_op(CMD_DIV, 32'd100, 32'd31);
      queue_op(CMD_DIV, 32'd100, 32'd13547);
      queue_op(CMD_DIV, 32'hFFFF_FFFF, 32'd1);
      queue_op(CMD_DIV, 32'd0, 32'd1);
      queue_op(CMD_DIV, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_op(CMD_DIV, 32'hAAAA_AAAA, 32'h5555_5555);
      queue_op(CMD_DIV, 32'd13546, 32'd2);
      queue_op(CMD_MUL, 32'd13546, 32'd13546);
      queue_op(CMD_SUB, 32'd7, 32'd7);
      queue_random(RANDOM_PER_PHASE);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (accepted_count == queued_count);
      tx_idle_pct = 63;
      rx_idle_pct = 29;
      queue_random(RANDOM_PER_PHASE);
      wait (accepted_count == queued_count);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      queue_random(RANDOM_PER_PHASE);
      wait (accepted_count == queued_count);
      wait (expected_results.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("PASS rns_alu_with_crt_reconstruction");
      end else begin
         $display("FAIL rns_alu_with_crt_reconstruction");
      end
      $finish;
   end

endmodule

`default_nettype wire
